>>> design/mfr_pkg.sv
package mfr_pkg;

  localparam int MARKER_CAP = 8;
  localparam int PAYLOAD_CAP = 8;
  localparam int HOLD_MAX = MARKER_CAP - 1;
  localparam int RES_MAX = 8;
  localparam int Q_DEPTH = 16;

  typedef enum logic [1:0] {
    REG_MARKER_BYTES  = 2'd0,
    REG_MARKER_LEN    = 2'd1,
    REG_PAYLOAD_BYTES = 2'd2,
    REG_PAYLOAD_LEN   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] marker_bytes;
    logic [3:0]  key_len;
    logic [63:0] payload_bytes;
    logic [3:0]  repl_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } res_t;

endpackage

>>> design/mfr_qcell.sv
module mfr_qcell import mfr_pkg::*; (
  input  logic clk,
  input  logic shift,
  input  logic load,
  input  res_t load_data,
  input  res_t next_data,
  output res_t data
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= next_data;
    end
  end

endmodule

>>> design/mfr_window.sv
module mfr_window import mfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output res_t [RES_MAX-1:0]    batch,
  output logic [3:0]            batch_cnt,
  output logic [2:0]            held_cnt
);

  logic [7:0] held [HOLD_MAX];
  logic [7:0] held_next [HOLD_MAX];
  logic [2:0] held_count;
  logic [2:0] held_count_next;
  logic [7:0] win [MARKER_CAP];
  logic [MARKER_CAP-1:0] eq;
  logic [3:0] n, mlen, plen, w, start, pre, tstart, tcnt;
  logic [4:0] total;
  logic [4:0] idx [RES_MAX];
  logic [3:0] sidx [HOLD_MAX];
  logic fill, match, empty;

  always_comb begin
    mlen = (cfg.key_len > 4'(MARKER_CAP)) ? 4'(MARKER_CAP) : cfg.key_len;
    plen = (cfg.repl_len > 4'(PAYLOAD_CAP)) ? 4'(PAYLOAD_CAP) : cfg.repl_len;
    w = (mlen == 4'd0) ? 4'd1 : mlen;
    n = {1'b0, held_count} + 4'd1;

    for (int i = 0; i < HOLD_MAX; i++) begin
      win[i] = (3'(i) == held_count) ? in_byte : held[i];
    end
    win[MARKER_CAP-1] = in_byte;

    for (int i = 0; i < MARKER_CAP; i++) begin
      eq[i] = (4'(i) >= mlen) || (win[i] == cfg.marker_bytes[8*i +: 8]);
    end

    fill = (n >= w);
    match = fill && (mlen != 4'd0) && (&eq);
    start = match ? mlen : (fill ? 4'd1 : 4'd0);
    pre = match ? plen : 4'd0;
    tstart = match ? mlen : 4'd0;
    tcnt = in_last ? (n - tstart) : ((fill && !match) ? 4'd1 : 4'd0);
    total = {1'b0, pre} + {1'b0, tcnt};
    empty = in_last && (total == 5'd0);

    if (empty) begin
      batch_cnt = 4'd1;
    end else if (total > 5'(RES_MAX)) begin
      batch_cnt = 4'(RES_MAX);
    end else begin
      batch_cnt = total[3:0];
    end

    for (int j = 0; j < RES_MAX; j++) begin
      idx[j] = {1'b0, tstart} + 5'(j) - {1'b0, pre};
      if (empty) begin
        batch[j].data = 8'h00;
      end else if (4'(j) < pre) begin
        batch[j].data = cfg.payload_bytes[8*j +: 8];
      end else begin
        batch[j].data = win[idx[j][2:0]];
      end
      batch[j].has_byte = !empty;
      batch[j].last = in_last && (4'(j) == batch_cnt - 4'd1);
    end

    for (int i = 0; i < HOLD_MAX; i++) begin
      sidx[i] = start + 4'(i);
      held_next[i] = win[sidx[i][2:0]];
    end
    held_count_next = in_last ? 3'd0 : 3'(n - start);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 3'd0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < HOLD_MAX; i++) begin
        held[i] <= held_next[i];
      end
    end
  end

  assign held_cnt = held_count;

endmodule

>>> design/marker_find_and_replace.sv
// Streaming marker find-and-replace.
// Input channel (in_valid/in_stall) carries template bytes, in_last on the
// final byte of a stream. Output channel (out_valid/out_stall) carries one
// result per transfer: out_byte with has_byte, out_last on the final result
// of the stream; an end result with has_byte low appears only when the last
// input produced nothing else.
// Configuration (cfg_write/cfg_index/cfg_data) sets marker and payload and
// their lengths; write it only while the block is idle.
// Results are registered in queue cells. Throughput: one input byte per cycle
// while in_stall is low and one result per cycle while out_stall is low. Each
// input yields 0 to 8 results into a 16-entry chain of queue cells; in_stall
// rises while more than 8 entries are queued, so with out_stall low only
// payloads longer than the marker, or a flush on in_last, hold the input back.
// Reset clears the held window count and the queue and loads the register
// defaults (marker length 1, everything else 0). A stalled receiver simply
// keeps the head cell in place; the queue fills and then stalls the input.
module marker_find_and_replace import mfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic        out_last
);

  cfg_t cfg;
  res_t [RES_MAX-1:0] batch;
  logic [3:0] batch_cnt;
  logic [2:0] held_cnt;
  logic [4:0] q_count;
  logic [4:0] q_count_next;
  logic [4:0] base;
  logic push, pop;
  res_t q_data [Q_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.marker_bytes <= 64'd0;
      cfg.key_len <= 4'd1;
      cfg.payload_bytes <= 64'd0;
      cfg.repl_len <= 4'd0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MARKER_BYTES:  cfg.marker_bytes <= cfg_data;
        REG_MARKER_LEN:    cfg.key_len <= cfg_data[3:0];
        REG_PAYLOAD_BYTES: cfg.payload_bytes <= cfg_data;
        REG_PAYLOAD_LEN:   cfg.repl_len <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (q_count > 5'(Q_DEPTH - RES_MAX));
  assign push = in_valid && !in_stall;
  assign out_valid = (q_count != 5'd0);
  assign pop = out_valid && !out_stall;
  assign base = q_count - {4'd0, pop};
  assign q_count_next = base + (push ? {1'b0, batch_cnt} : 5'd0);

  mfr_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (push),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .batch     (batch),
    .batch_cnt (batch_cnt),
    .held_cnt  (held_cnt)
  );

  genvar k;
  generate
    for (k = 0; k < Q_DEPTH; k++) begin : g_cell
      logic [4:0] diff;
      logic load;
      res_t next_data;

      assign diff = 5'(k) - base;
      assign load = push && (5'(k) >= base) && (5'(k) < base + {1'b0, batch_cnt});

      if (k == Q_DEPTH - 1) begin : g_tail
        assign next_data = '0;
      end else begin : g_mid
        assign next_data = q_data[k+1];
      end

      mfr_qcell u_cell (
        .clk       (clk),
        .shift     (pop),
        .load      (load),
        .load_data (batch[diff[2:0]]),
        .next_data (next_data),
        .data      (q_data[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 5'd0;
    end else begin
      q_count <= q_count_next;
    end
  end

  assign out_byte = q_data[0].data;
  assign has_byte = q_data[0].has_byte;
  assign out_last = q_data[0].last;

`ifndef ASSERT_OFF
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= 5'(Q_DEPTH))
    else $error("queue count above depth");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> out_last)
    else $error("empty result without end mark");

  a_last_flushes: assert property (@(posedge clk) disable iff (rst)
    push && in_last |=> held_cnt == 3'd0)
    else $error("window not flushed after last request");

  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    push && in_last |-> batch_cnt != 4'd0)
    else $error("last request produced no result");
`endif

endmodule

>>> tb/tb.sv
module tb;
  import mfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTS = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  reg_idx_t    cfg_index = REG_MARKER_BYTES;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        out_last;

  marker_find_and_replace u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .out_last  (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block's registers and window
  logic [63:0] mk_bytes = '0;
  logic [3:0]  mk_len = 4'd1;
  logic [63:0] pl_bytes = '0;
  logic [3:0]  pl_len = '0;
  logic [7:0]  held [0:7];
  int          held_n = 0;

  res_t want_q[$];

  int errors = 0;
  int sent = 0;
  int checked = 0;
  int streams = 0;
  int hits = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int quiet = 0;
  bit ab_mode = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic void add_res(ref res_t q[$], input logic [7:0] d, input logic h);
    res_t r;
    r.data = d;
    r.has_byte = h;
    r.last = 1'b0;
    if (q.size() < RES_MAX) q.push_back(r);
  endfunction

  // Expected results of one accepted template byte.
  task automatic replace_step(input logic [7:0] b, input logic l);
    logic [7:0] win [0:8];
    res_t outs[$];
    int n, ml, pl, w, start;
    logic hit;
    n = held_n;
    ml = (mk_len > 4'd8) ? 8 : int'(mk_len);
    pl = (pl_len > 4'd8) ? 8 : int'(pl_len);
    w = (ml != 0) ? ml : 1;
    start = 0;
    for (int i = 0; i < n; i++) win[i] = held[i];
    win[n] = b;
    n++;
    if (n >= w) begin
      hit = (ml != 0);
      for (int i = 0; i < ml; i++)
        if (mk_bytes[8*i +: 8] != win[i]) hit = 1'b0;
      if (hit) begin
        hits++;
        for (int i = 0; i < pl; i++) add_res(outs, pl_bytes[8*i +: 8], 1'b1);
        start = ml;
      end else begin
        add_res(outs, win[0], 1'b1);
        start = 1;
      end
    end
    if (l) begin
      for (int i = start; i < n; i++) add_res(outs, win[i], 1'b1);
      held_n = 0;
      if (outs.size() == 0) add_res(outs, 8'h00, 1'b0);
      outs[outs.size()-1].last = 1'b1;
    end else begin
      held_n = n - start;
      for (int i = 0; i < held_n; i++) held[i] = win[start + i];
    end
    foreach (outs[i]) want_q.push_back(outs[i]);
  endtask

  task automatic send_req(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < tx_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sent++;
    replace_step(b, l);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MARKER_BYTES:  mk_bytes = v;
      REG_MARKER_LEN:    mk_len = v[3:0];
      REG_PAYLOAD_BYTES: pl_bytes = v;
      REG_PAYLOAD_LEN:   pl_len = v[3:0];
      default: ;
    endcase
  endtask

  // output checker
  always @(posedge clk) begin : chk_out
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        report_mismatch("unexpected result", out_byte, 0);
      end else begin
        e = want_q.pop_front();
        checked++;
        if (out_byte !== e.data) report_mismatch("out_byte", out_byte, e.data);
        if (has_byte !== e.has_byte) report_mismatch("has_byte", has_byte, e.has_byte);
        if (out_last !== e.last) report_mismatch("out_last", out_last, e.last);
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < rx_pct);

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[marker_find_and_replace] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // reset defaults: zero marker of length one, empty payload
  task automatic test_defaults();
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b1);
  endtask

  task automatic test_expand();
    settle();
    write_reg(REG_MARKER_BYTES, 64'h0000_0000_0043_4241);
    write_reg(REG_MARKER_LEN, 64'd3);
    write_reg(REG_PAYLOAD_BYTES, 64'hFF00_A55A_0180_7F00);
    write_reg(REG_PAYLOAD_LEN, 64'd8);
    send_req(8'h41, 1'b0);
    send_req(8'h42, 1'b0);
    send_req(8'h43, 1'b0);
    send_req(8'h41, 1'b0);
    send_req(8'h41, 1'b0);
    send_req(8'h42, 1'b0);
    send_req(8'h43, 1'b0);
    send_req(8'h41, 1'b0);
    send_req(8'h42, 1'b1);
  endtask

  // oversized lengths clamp to eight
  task automatic test_clamp();
    settle();
    write_reg(REG_MARKER_BYTES, '1);
    write_reg(REG_MARKER_LEN, 64'd15);
    write_reg(REG_PAYLOAD_BYTES, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_PAYLOAD_LEN, 64'd15);
    for (int i = 0; i < 8; i++) send_req(8'hFF, i == 7);
  endtask

  task automatic test_no_marker();
    settle();
    write_reg(REG_MARKER_LEN, 64'd0);
    send_req(8'h5A, 1'b0);
    send_req(8'hA5, 1'b1);
  endtask

  // shorter marker while bytes are held; overflow past eight results
  task automatic test_shrink_held();
    settle();
    write_reg(REG_MARKER_BYTES, 64'h0000_0000_4433_2211);
    write_reg(REG_MARKER_LEN, 64'd4);
    send_req(8'h11, 1'b0);
    send_req(8'h33, 1'b0);
    send_req(8'h44, 1'b0);
    settle();
    write_reg(REG_MARKER_LEN, 64'd1);
    write_reg(REG_PAYLOAD_BYTES, 64'h8877_6655_4433_2201);
    write_reg(REG_PAYLOAD_LEN, 64'd8);
    send_req(8'h99, 1'b1);
  endtask

  task automatic random_config();
    logic [63:0] v;
    settle();
    ab_mode = ($urandom_range(0, 3) == 0);
    v = {$urandom, $urandom};
    if (ab_mode)
      for (int i = 0; i < 8; i++) v[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
    write_reg(REG_MARKER_BYTES, v);
    if ($urandom_range(0, 9) == 0) v = 64'($urandom_range(0, 15));
    else v = 64'($urandom_range(1, 8));
    write_reg(REG_MARKER_LEN, v);
    if ($urandom_range(0, 3) != 0) write_reg(REG_PAYLOAD_BYTES, {$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 9) == 0) v = 64'($urandom_range(0, 15));
      else v = 64'($urandom_range(0, 8));
      write_reg(REG_PAYLOAD_LEN, v);
    end
  endtask

  task automatic run_stream(input int target);
    logic [7:0] tpl[$];
    int ml, sel, k;
    ml = (mk_len > 4'd8) ? 8 : int'(mk_len);
    while (tpl.size() < target) begin
      sel = $urandom_range(0, 9);
      if (sel < 4 && ml > 0) begin
        for (int i = 0; i < ml; i++) tpl.push_back(mk_bytes[8*i +: 8]);
      end else if (sel < 6 && ml > 1) begin
        k = $urandom_range(1, ml - 1);
        for (int i = 0; i < k; i++) tpl.push_back(mk_bytes[8*i +: 8]);
      end else if (sel < 8) begin
        if (ab_mode) tpl.push_back($urandom_range(0, 1) ? 8'h61 : 8'h62);
        else tpl.push_back(mk_bytes[8*$urandom_range(0, 7) +: 8]);
      end else begin
        tpl.push_back(8'($urandom));
      end
    end
    foreach (tpl[i]) send_req(tpl[i], i == tpl.size() - 1);
    streams++;
  endtask

  task automatic test_random(input int tx, input int rx, input int count);
    int stop;
    tx_pct = tx;
    rx_pct = rx;
    stop = sent + count;
    random_config();
    while (sent < stop) begin
      if ($urandom_range(0, 2) == 0) random_config();
      run_stream($urandom_range(1, 16));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_expand();
    test_clamp();
    test_no_marker();
    test_shrink_held();
    test_random(9, 68, 80);
    test_random(68, 9, 80);
    test_random(0, 0, 80);
    settle();
    $display("covered %0d requests in %0d random streams, %0d marker hits", sent, streams,
             hits);
    $display("%0d results checked, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("[marker_find_and_replace] OK");
    end else begin
      $display("[marker_find_and_replace] ERROR");
    end
    $finish;
  end

endmodule
